>>> rtl/bsp_pkg.sv
package bsp_pkg;

   // sizes from the knot format and the configured limits
   localparam int MAX_DEGREE = 3;
   localparam int MAX_KNOTS  = 16;
   localparam int FRAC_BITS  = 16;
   localparam int KNOT_W     = 24;
   localparam int IDX_W      = 4;
   localparam int DEG_W      = 2;
   localparam int RIDX_W     = 2;
   localparam int BASIS_W    = FRAC_BITS + 1;
   localparam int DEN_W      = KNOT_W + 1;
   localparam int PROD_W     = DEN_W + BASIS_W + 1;
   localparam int CNT_W      = $clog2(PROD_W);
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [BASIS_W-1:0] ONE_Q = BASIS_W'(1) << FRAC_BITS;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EVAL  = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STAT_W-1:0] ST_ZERO_DEN = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_CTRL = 2'd1;

endpackage

>>> rtl/bsp_if.sv
interface bsp_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [bsp_pkg::IDX_W-1:0]     knot_index;
   logic [bsp_pkg::KNOT_W-1:0]    knot_value;
   logic [bsp_pkg::KNOT_W-1:0]    param_u;
   modport source (output valid, req_type, knot_index, knot_value, param_u,
                   input ready);
   modport sink (input valid, req_type, knot_index, knot_value, param_u,
                 output ready);
endinterface

interface bsp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bsp_pkg::IDX_W-1:0]     span_index;
   logic [bsp_pkg::RIDX_W-1:0]    basis_index;
   logic [bsp_pkg::BASIS_W-1:0]   basis_value;
   logic [bsp_pkg::STAT_W-1:0]    status;
   logic                          last;
   modport source (output valid, span_index, basis_index, basis_value, status, last,
                   input ready);
   modport sink (input valid, span_index, basis_index, basis_value, status, last,
                 output ready);
endinterface

interface bsp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bsp_pkg::CSR_IDX_W-1:0]   index;
   logic [bsp_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/bsp_div.sv
module bsp_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [bsp_pkg::PROD_W-1:0]  dividend,
   input  logic signed [bsp_pkg::DEN_W-1:0]   divisor,
   output logic                               done,
   output logic signed [bsp_pkg::PROD_W-1:0]  quotient
);

   logic                          busy_ff;
   logic                          done_ff;
   logic                          neg_ff;
   logic [bsp_pkg::CNT_W-1:0]     cnt_ff;
   logic [bsp_pkg::DEN_W-1:0]     rem_ff;
   logic [bsp_pkg::DEN_W-1:0]     dmag_ff;
   logic [bsp_pkg::PROD_W-1:0]    qmag_ff;
   logic [bsp_pkg::DEN_W:0]       trial;
   logic                          fits;

   // one restoring step per cycle on magnitudes
   assign trial = {rem_ff, qmag_ff[bsp_pkg::PROD_W-1]};
   assign fits  = trial >= {1'b0, dmag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            qmag_ff <= dividend[bsp_pkg::PROD_W-1] ? -dividend : dividend;
            dmag_ff <= divisor[bsp_pkg::DEN_W-1] ? -divisor : divisor;
            neg_ff  <= dividend[bsp_pkg::PROD_W-1] ^ divisor[bsp_pkg::DEN_W-1];
         end else if (busy_ff) begin
            rem_ff  <= fits ? bsp_pkg::DEN_W'(trial - {1'b0, dmag_ff})
                            : trial[bsp_pkg::DEN_W-1:0];
            qmag_ff <= {qmag_ff[bsp_pkg::PROD_W-2:0], fits};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == bsp_pkg::CNT_W'(bsp_pkg::PROD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // truncation toward zero: sign applied to the magnitude quotient
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(qmag_ff) : $signed(qmag_ff);

endmodule

>>> rtl/bspline_span_and_basis.sv
// channel   | direction | beat contents
// req_chan  | in        | req_type, knot_index, knot_value, param_u
// rsp_chan  | out       | span_index, basis_index, basis_value, status, last
// csr_chan  | in        | index (0 degree, 1 last control index), data
//
// an evaluation does the range check and span scan, one knot memory read per
// cycle, then p*(p+1)/2 recurrence steps, each with two divisions by the
// one-bit-per-cycle divider (skipped on a zero denominator); then p+1 result
// beats, or a single range beat when the configuration or u is out of range.
// reset is synchronous: degree 2, last control index 7; knots are undefined
// until written. a stalled rsp_chan holds the beat in the output register.
module bspline_span_and_basis (
   input logic          clock,
   input logic          reset,
   bsp_req_if.sink      req_chan,
   bsp_rsp_if.source    rsp_chan,
   bsp_csr_if.sink      csr_chan
);

   typedef enum logic [3:0] {
      S_IDLE, S_LO, S_HI, S_SCAN, S_RHI, S_RLO, S_RDEN,
      S_MULR, S_DVSR, S_DVWR, S_MULL, S_DVSL, S_DVWL, S_UPD, S_OUT, S_OOR
   } state_type;

   state_type                            state_ff;
   logic [bsp_pkg::DEG_W-1:0]            degree_ff;
   logic [bsp_pkg::IDX_W-1:0]            last_ctrl_ff;
   logic [bsp_pkg::KNOT_W-1:0]           u_ff;
   logic [bsp_pkg::IDX_W-1:0]            span_ff;
   logic [bsp_pkg::IDX_W-1:0]            k_ff;
   logic [bsp_pkg::RIDX_W-1:0]           j_ff;
   logic [bsp_pkg::RIDX_W-1:0]           r_ff;
   logic                                 zero_ff;
   logic [bsp_pkg::KNOT_W-1:0]           hi_ff;
   logic signed [bsp_pkg::DEN_W-1:0]     den_ff;
   logic signed [bsp_pkg::DEN_W-1:0]     dr_ff;
   logic signed [bsp_pkg::DEN_W-1:0]     dl_ff;
   logic signed [bsp_pkg::PROD_W-1:0]    prod_ff;
   logic signed [bsp_pkg::PROD_W-1:0]    tr_ff;
   logic signed [bsp_pkg::PROD_W-1:0]    saved_ff;
   logic [bsp_pkg::BASIS_W-1:0]          nb_ff [bsp_pkg::MAX_DEGREE+1];

   logic [bsp_pkg::KNOT_W-1:0]           knot_mem [bsp_pkg::MAX_KNOTS];
   logic [bsp_pkg::KNOT_W-1:0]           rdata_ff;
   logic [bsp_pkg::IDX_W-1:0]            rd_addr;

   logic                                 rsp_valid_ff;
   logic [bsp_pkg::IDX_W-1:0]            rsp_span_ff;
   logic [bsp_pkg::RIDX_W-1:0]           rsp_ridx_ff;
   logic [bsp_pkg::BASIS_W-1:0]          rsp_value_ff;
   logic [bsp_pkg::STAT_W-1:0]           rsp_status_ff;
   logic                                 rsp_last_ff;

   logic                                 req_fire;
   logic                                 slot_free;
   logic                                 rsp_load;
   logic                                 bad_cfg;
   logic [bsp_pkg::IDX_W:0]              cfg_sum;
   logic signed [bsp_pkg::DEN_W-1:0]     den_now;
   logic [bsp_pkg::BASIS_W-1:0]          nb_r;
   logic                                 div_start;
   logic                                 div_done;
   logic signed [bsp_pkg::PROD_W-1:0]    div_q;
   logic [bsp_pkg::IDX_W:0]              hi_addr;

   // clamp a recurrence value to 0..1.0
   function automatic logic [bsp_pkg::BASIS_W-1:0] sat_unit(
      input logic signed [bsp_pkg::PROD_W:0] v);
      logic [bsp_pkg::BASIS_W-1:0] res;
      if (v < 0) res = '0;
      else if (v > $signed({1'b0, bsp_pkg::PROD_W'(bsp_pkg::ONE_Q)})) res = bsp_pkg::ONE_Q;
      else res = v[bsp_pkg::BASIS_W-1:0];
      return res;
   endfunction

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load  = ((state_ff == S_OUT) || (state_ff == S_OOR)) && slot_free;

   // configuration sanity: need p <= n and n+p+1 inside the store
   assign cfg_sum = {1'b0, last_ctrl_ff} + {3'b000, degree_ff} + 5'd1;
   assign bad_cfg = (last_ctrl_ff < {2'b00, degree_ff}) || cfg_sum[bsp_pkg::IDX_W];

   assign den_now   = $signed({1'b0, hi_ff}) - $signed({1'b0, rdata_ff});
   assign nb_r      = nb_ff[r_ff];
   assign div_start = (state_ff == S_DVSR) || (state_ff == S_DVSL);
   assign hi_addr   = {1'b0, span_ff} + {3'b000, r_ff} + 5'd1;

   // knot memory read address per state
   always_comb begin
      unique case (state_ff)
         S_IDLE:  rd_addr = {2'b00, degree_ff};
         S_LO:    rd_addr = bsp_pkg::IDX_W'(cfg_sum - {3'b000, degree_ff});
         S_HI:    rd_addr = bsp_pkg::IDX_W'({2'b00, degree_ff} + 4'd1);
         S_SCAN:  rd_addr = k_ff + 1'b1;
         S_RHI:   rd_addr = hi_addr[bsp_pkg::IDX_W-1:0];
         S_RLO:   rd_addr = bsp_pkg::IDX_W'(hi_addr - {3'b000, j_ff});
         default: rd_addr = '0;
      endcase
   end

   // knot store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req_fire && req_chan.req_type == bsp_pkg::REQ_WRITE)
         knot_mem[req_chan.knot_index] <= req_chan.knot_value;
      rdata_ff <= knot_mem[rd_addr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff    <= 2'd2;
         last_ctrl_ff <= 4'd7;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == bsp_pkg::CSR_DEGREE)
            degree_ff <= csr_chan.data[bsp_pkg::DEG_W-1:0];
         else if (csr_chan.index == bsp_pkg::CSR_LAST_CTRL)
            last_ctrl_ff <= csr_chan.data;
      end
   end

   bsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // sequencer: range check, span scan, recurrence, result beats
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && req_chan.req_type == bsp_pkg::REQ_EVAL) begin
                  u_ff     <= req_chan.param_u;
                  nb_ff[0] <= bsp_pkg::ONE_Q;
                  zero_ff  <= 1'b0;
                  state_ff <= bad_cfg ? S_OOR : S_LO;
               end
            end
            S_LO: begin
               state_ff <= (u_ff < rdata_ff) ? S_OOR : S_HI;
            end
            S_HI: begin
               span_ff <= {2'b00, degree_ff};
               k_ff    <= {2'b00, degree_ff} + 4'd1;
               j_ff    <= 2'd1;
               r_ff    <= '0;
               if (u_ff > rdata_ff) state_ff <= S_OOR;
               else if ({2'b00, degree_ff} < last_ctrl_ff) state_ff <= S_SCAN;
               else state_ff <= (degree_ff == 2'd0) ? S_OUT : S_RHI;
            end
            S_SCAN: begin
               if (rdata_ff <= u_ff) span_ff <= k_ff;
               k_ff <= k_ff + 1'b1;
               if (k_ff >= last_ctrl_ff)
                  state_ff <= (degree_ff == 2'd0) ? S_OUT : S_RHI;
            end
            S_RHI: begin
               saved_ff <= (r_ff == 2'd0) ? '0 : saved_ff;
               state_ff <= S_RLO;
            end
            S_RLO: begin
               hi_ff    <= rdata_ff;
               state_ff <= S_RDEN;
            end
            S_RDEN: begin
               den_ff <= den_now;
               dr_ff  <= $signed({1'b0, hi_ff}) - $signed({1'b0, u_ff});
               dl_ff  <= $signed({1'b0, u_ff}) - $signed({1'b0, rdata_ff});
               if (den_now == 0) begin
                  zero_ff  <= 1'b1;
                  tr_ff    <= '0;
                  prod_ff  <= '0;
                  state_ff <= S_UPD;
               end else begin
                  state_ff <= S_MULR;
               end
            end
            S_MULR: begin
               prod_ff  <= bsp_pkg::PROD_W'(dr_ff)
                           * bsp_pkg::PROD_W'($signed({1'b0, nb_r}));
               state_ff <= S_DVSR;
            end
            S_DVSR: state_ff <= S_DVWR;
            S_DVWR: begin
               if (div_done) begin
                  tr_ff    <= div_q;
                  state_ff <= S_MULL;
               end
            end
            S_MULL: begin
               prod_ff  <= bsp_pkg::PROD_W'(dl_ff)
                           * bsp_pkg::PROD_W'($signed({1'b0, nb_r}));
               state_ff <= S_DVSL;
            end
            S_DVSL: state_ff <= S_DVWL;
            S_DVWL: begin
               if (div_done) begin
                  prod_ff  <= div_q;
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               // prod_ff now holds the left term
               nb_ff[r_ff] <= sat_unit({saved_ff[bsp_pkg::PROD_W-1], saved_ff}
                                       + {tr_ff[bsp_pkg::PROD_W-1], tr_ff});
               saved_ff    <= prod_ff;
               if (r_ff + 1'b1 < j_ff) begin
                  r_ff     <= r_ff + 1'b1;
                  state_ff <= S_RHI;
               end else begin
                  nb_ff[j_ff] <= sat_unit({prod_ff[bsp_pkg::PROD_W-1], prod_ff});
                  r_ff        <= '0;
                  if (j_ff == degree_ff) begin
                     state_ff <= S_OUT;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= S_RHI;
                  end
               end
            end
            S_OUT: begin
               if (slot_free) begin
                  rsp_span_ff   <= span_ff;
                  rsp_ridx_ff   <= r_ff;
                  rsp_value_ff  <= nb_r;
                  rsp_status_ff <= zero_ff ? bsp_pkg::ST_ZERO_DEN : bsp_pkg::ST_OK;
                  rsp_last_ff   <= (r_ff == degree_ff);
                  r_ff          <= r_ff + 1'b1;
                  if (r_ff == degree_ff) state_ff <= S_IDLE;
               end
            end
            S_OOR: begin
               if (slot_free) begin
                  rsp_span_ff   <= '0;
                  rsp_ridx_ff   <= '0;
                  rsp_value_ff  <= '0;
                  rsp_status_ff <= bsp_pkg::ST_RANGE;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result beat from the output register
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.span_index  = rsp_span_ff;
   assign rsp_chan.basis_index = rsp_ridx_ff;
   assign rsp_chan.basis_value = rsp_value_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.last        = rsp_last_ff;

endmodule

>>> tb/sv/bspline_span_and_basis_tb.sv
`timescale 1ns / 1ps

module bspline_span_and_basis_tb;

   localparam int  HALF_PERIOD = 6;
   localparam int  DRAIN_WAIT  = 900;
   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  HOLD_LEN    = 400;

   typedef struct packed {
      logic                               req_type;
      logic [bsp_pkg::IDX_W-1:0]          knot_index;
      logic [bsp_pkg::KNOT_W-1:0]         knot_value;
      logic [bsp_pkg::KNOT_W-1:0]         param_u;
   } knot_req_type;

   typedef struct packed {
      logic [bsp_pkg::IDX_W-1:0]          span_index;
      logic [bsp_pkg::RIDX_W-1:0]         basis_index;
      logic [bsp_pkg::BASIS_W-1:0]        basis_value;
      logic [bsp_pkg::STAT_W-1:0]         status;
      logic                               last;
   } basis_beat_type;

   logic clock;
   logic reset;

   bsp_req_if req_chan ();
   bsp_rsp_if rsp_chan ();
   bsp_csr_if csr_chan ();

   bspline_span_and_basis u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   // shadow of the block state
   logic [bsp_pkg::KNOT_W-1:0]     knot_mirror [bsp_pkg::MAX_KNOTS];
   logic [bsp_pkg::DEG_W-1:0]      degree_mirror;
   logic [bsp_pkg::IDX_W-1:0]      last_ctrl_mirror;

   knot_req_type    pending_reqs [$];
   basis_beat_type  expected_basis [$];
   knot_req_type    driven_req;
   int              error_count;
   int              idle_mode;
   int              hold_start;
   int              hold_seen;
   int              hold_cnt;
   longint          cycle_count;

   always #(HALF_PERIOD) clock = ~clock;

   function automatic longint clamp_unit(longint v);
      if (v < 0) return 0;
      if (v > (longint'(1) << bsp_pkg::FRAC_BITS)) return longint'(1) << bsp_pkg::FRAC_BITS;
      return v;
   endfunction

   // work out the basis beats for one evaluate beat
   function automatic void predict_basis(logic [bsp_pkg::KNOT_W-1:0] u_in);
      longint u, saved, hi, lo, den, tr, tl;
      longint nb [bsp_pkg::MAX_DEGREE+1];
      int p, n, span;
      bit zero_den;
      basis_beat_type b;
      p = degree_mirror;
      n = last_ctrl_mirror;
      u = u_in;
      zero_den = 0;
      if (n < p || n + p + 1 >= bsp_pkg::MAX_KNOTS || u < knot_mirror[p] ||
          u > knot_mirror[n+1]) begin
         b = '{span_index: '0, basis_index: '0, basis_value: '0,
               status: bsp_pkg::ST_RANGE, last: 1'b1};
         expected_basis = {expected_basis, b};
         return;
      end
      span = p;
      for (int k = p + 1; k <= n; k++)
         if (knot_mirror[k] <= u) span = k;
      nb[0] = longint'(1) << bsp_pkg::FRAC_BITS;
      for (int j = 1; j <= p; j++) begin
         saved = 0;
         for (int r = 0; r < j; r++) begin
            hi = knot_mirror[span + r + 1];
            lo = knot_mirror[span + r + 1 - j];
            den = hi - lo;
            tr = 0;
            tl = 0;
            if (den == 0) zero_den = 1;
            else begin
               tr = ((hi - u) * nb[r]) / den;
               tl = ((u - lo) * nb[r]) / den;
            end
            nb[r] = clamp_unit(saved + tr);
            saved = tl;
         end
         nb[j] = clamp_unit(saved);
      end
      for (int r = 0; r <= p; r++) begin
         b.span_index  = bsp_pkg::IDX_W'(span);
         b.basis_index = bsp_pkg::RIDX_W'(r);
         b.basis_value = bsp_pkg::BASIS_W'(nb[r]);
         b.status      = zero_den ? bsp_pkg::ST_ZERO_DEN : bsp_pkg::ST_OK;
         b.last        = (r == p);
         expected_basis = {expected_basis, b};
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      bit           accepted;
      bit           offer;
      knot_req_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         accepted = req_chan.valid && req_chan.ready;
         if (accepted) begin
            if (driven_req.req_type == bsp_pkg::REQ_WRITE)
               knot_mirror[driven_req.knot_index] = driven_req.knot_value;
            else predict_basis(driven_req.param_u);
         end
         if (!req_chan.valid || accepted) begin
            offer = pending_reqs.size() > 0;
            if (idle_mode == 0 && $urandom_range(99) < 29) offer = 0;
            if (idle_mode == 1 && $urandom_range(99) < 72) offer = 0;
            if (offer) begin
               nxt = pending_reqs.pop_front();
               driven_req <= nxt;
               req_chan.req_type   <= nxt.req_type;
               req_chan.knot_index <= nxt.knot_index;
               req_chan.knot_value <= nxt.knot_value;
               req_chan.param_u    <= nxt.param_u;
            end
            req_chan.valid <= offer;
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      basis_beat_type want;
      bit             rdy;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_cnt <= 0;
         hold_seen <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_basis.size() == 0) begin
               report_mismatch("unexpected beat", rsp_chan.basis_value, 0);
            end else begin
               want = expected_basis.pop_front();
               if (rsp_chan.span_index !== want.span_index)
                  report_mismatch("span_index", rsp_chan.span_index, want.span_index);
               if (rsp_chan.basis_index !== want.basis_index)
                  report_mismatch("basis_index", rsp_chan.basis_index, want.basis_index);
               if (rsp_chan.basis_value !== want.basis_value)
                  report_mismatch("basis_value", rsp_chan.basis_value, want.basis_value);
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", rsp_chan.status, want.status);
               if (rsp_chan.last !== want.last)
                  report_mismatch("last", rsp_chan.last, want.last);
            end
         end
         rdy = 1'b1;
         if (idle_mode == 0 && $urandom_range(99) < 72) rdy = 1'b0;
         if (idle_mode == 1 && $urandom_range(99) < 29) rdy = 1'b0;
         if (hold_seen != hold_start) begin
            hold_seen <= hold_start;
            hold_cnt <= HOLD_LEN;
            rdy = 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rdy = 1'b0;
         end
         rsp_chan.ready <= rdy;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bspline_span_and_basis_tb: errors");
         $finish;
      end
   end

   task automatic queue_knot(int idx, longint val);
      knot_req_type it;
      it = '{req_type: bsp_pkg::REQ_WRITE, knot_index: bsp_pkg::IDX_W'(idx),
             knot_value: bsp_pkg::KNOT_W'(val), param_u: bsp_pkg::KNOT_W'($urandom())};
      pending_reqs = {pending_reqs, it};
   endtask

   task automatic queue_eval(longint u);
      knot_req_type it;
      it = '{req_type: bsp_pkg::REQ_EVAL, knot_index: bsp_pkg::IDX_W'($urandom()),
             knot_value: bsp_pkg::KNOT_W'($urandom()), param_u: bsp_pkg::KNOT_W'(u)};
      pending_reqs = {pending_reqs, it};
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_chan.valid || expected_basis.size() > 0 ||
             hold_cnt > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // register write, only called with the block idle
   task automatic csr_write(logic [bsp_pkg::CSR_IDX_W-1:0] idx, int val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= bsp_pkg::CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_chan.ready);
      if (idx == bsp_pkg::CSR_DEGREE) degree_mirror = bsp_pkg::DEG_W'(val);
      else if (idx == bsp_pkg::CSR_LAST_CTRL) last_ctrl_mirror = bsp_pkg::IDX_W'(val);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // nondecreasing knot vector, sometimes fully random
   task automatic queue_knot_vector(int style);
      logic [bsp_pkg::KNOT_W-1:0] v;
      v = (style == 2) ? bsp_pkg::KNOT_W'(24'hF00000 + $urandom_range(0, 24'h0FFFF))
                       : bsp_pkg::KNOT_W'($urandom_range(0, 24'h20000));
      for (int k = 0; k < bsp_pkg::MAX_KNOTS; k++) begin
         if (style == 1) queue_knot(k, $urandom());
         else begin
            queue_knot(k, v);
            if ($urandom_range(3) != 0)
               v = v + bsp_pkg::KNOT_W'(style == 2 ? $urandom_range(1, 24'h0FFF)
                                                   : $urandom_range(1, 24'h30000));
         end
      end
   endtask

   initial begin
      int                         p, n, style;
      logic [bsp_pkg::KNOT_W-1:0] lo_k, hi_k;
      clock = 1'b0;
      reset = 1'b1;
      cycle_count = 0;
      error_count = 0;
      idle_mode = 0;
      hold_start = 0;
      degree_mirror = 2;
      last_ctrl_mirror = 7;
      req_chan.valid = 1'b0;
      req_chan.req_type = bsp_pkg::REQ_WRITE;
      req_chan.knot_index = '0;
      req_chan.knot_value = '0;
      req_chan.param_u = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = bsp_pkg::CSR_DEGREE;
      csr_chan.data = '0;
      foreach (knot_mirror[k]) knot_mirror[k] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // clamped vector with repeated end knots, reset configuration
      for (int k = 0; k < bsp_pkg::MAX_KNOTS; k++)
         queue_knot(k, (k < 3) ? 24'h0 : (k > 8) ? 24'h060000
                                      : bsp_pkg::KNOT_W'((k - 2) << 16));
      queue_eval(24'h000000);
      queue_eval(24'h060000);
      queue_eval(24'h030000);
      queue_eval(24'h028000);
      queue_eval(24'h060001);
      queue_eval(24'hFFFFFF);
      wait_idle();
      // largest degree, bad then good last index
      csr_write(bsp_pkg::CSR_DEGREE, 3);
      csr_write(bsp_pkg::CSR_LAST_CTRL, 12);
      queue_eval(24'h010000);
      wait_idle();
      csr_write(bsp_pkg::CSR_LAST_CTRL, 11);
      queue_knot(3, 24'h008000);
      queue_eval(24'h004000);
      queue_eval(24'h008000);
      queue_knot(5, 24'h000100);
      queue_eval(24'h020000);
      wait_idle();
      csr_write(bsp_pkg::CSR_DEGREE, 0);
      csr_write(bsp_pkg::CSR_LAST_CTRL, 0);
      queue_eval(24'h000000);
      wait_idle();
      csr_write(bsp_pkg::CSR_DEGREE, 1);
      csr_write(bsp_pkg::CSR_LAST_CTRL, 14);
      queue_eval(24'h000000);
      wait_idle();

      // random phases with changing configuration and idling
      for (int ph = 0; ph < 12; ph++) begin
         idle_mode = ph / 4;
         if (ph > 0) begin
            p = $urandom_range(0, 3);
            n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(p, 14 - p);
            if (ph == 5) begin
               p = 3;
               n = 12 - 3 + 0;
            end
            csr_write(bsp_pkg::CSR_DEGREE, p);
            csr_write(bsp_pkg::CSR_LAST_CTRL, n);
         end
         style = $urandom_range(0, 5) == 0 ? 1 : (ph == 7 ? 2 : 0);
         queue_knot_vector(style);
         while (pending_reqs.size() > 0) @(posedge clock);
         if (ph == 2) hold_start = hold_start + 1;
         p = degree_mirror;
         n = last_ctrl_mirror;
         lo_k = knot_mirror[p];
         hi_k = knot_mirror[(n + 1) % bsp_pkg::MAX_KNOTS];
         for (int e = 0; e < 16; e++) begin
            if ($urandom_range(0, 6) == 0 || lo_k > hi_k) queue_eval($urandom());
            else if ($urandom_range(0, 9) == 0) queue_eval(knot_mirror[$urandom_range(0, 15)]);
            else queue_eval($urandom_range(lo_k, hi_k));
         end
         wait_idle();
      end

      if (error_count == 0) $display("bspline_span_and_basis_tb: clean");
      else $display("bspline_span_and_basis_tb: errors");
      $finish;
   end

endmodule
